// File: rtl/utn_pkg.sv
package utn_pkg;

   // default word buffer depth and result limit per transaction
   localparam int WORD_DEPTH_DEF = 32;
   localparam int MAX_RESULTS    = 40;
   localparam int CNT_W          = $clog2(MAX_RESULTS + 1);

   // character codes
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_APOS   = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_Z  = 8'h7A;
   localparam logic [7:0] CASE_OFS  = 8'h20;

   // commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic take_slot;
      logic rd;
      logic emit;
      logic skip;
      logic flush_end;
      logic push_wr;
      logic marker;
      logic final_flush;
   } utn_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic slot_any;
      logic need_flush;
      logic idx_at_fill;
      logic capped;
      logic out_free;
      logic line_end;
      logic n_zero;
   } utn_status_type;

   // whitespace: tab through carriage return, and space
   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

endpackage

// File: rtl/utterance_text_normalizer_unit.sv
// utterance text normalizer
// input channel req_*: one text byte per transaction plus req_line_end on the
// last byte of an utterance. result channel rsp_*: zero or more normalized
// bytes per input transaction; rsp_last_of_line marks the final result of an
// utterance, and an utterance with no output byte yields one end marker with
// rsp_char_valid low.
// bytes are held in a word buffer of WORD_DEPTH entries until whitespace, a
// full buffer or line end flushes them, so results lag the input by up to one word.
// timing: req_stall drops only while the controller is idle. a dropped byte
// passes from accept through dispatch back to idle, and each buffer write
// adds a dispatch step and a push-check step; each byte flushed out of the
// buffer adds one buffer read and one output load when whitespace, a full
// buffer or line end flushes the word. the single-ported word buffer and
// the output register set these steps.
// a result leaves through a one-entry output register; while rsp_stall is
// high it holds its payload and the flush waits.
// reset (synchronous, active high) empties the buffer and clears the dash and
// comment flags; no clearing pass is needed.
module utterance_text_normalizer_unit #(
   parameter int WORD_DEPTH = utn_pkg::WORD_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_char,
   input  logic       req_line_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_char_valid,
   output logic       rsp_last_of_line
);
   import utn_pkg::*;

   utn_cmd_type    cmd;
   utn_status_type status;

   // sequencer
   utn_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // buffer, flags and output register
   utn_datapath #(
      .WORD_DEPTH (WORD_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_in_char      (req_in_char),
      .req_line_end     (req_line_end),
      .cmd              (cmd),
      .status           (status),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_out_char     (rsp_out_char),
      .rsp_char_valid   (rsp_char_valid),
      .rsp_last_of_line (rsp_last_of_line)
   );

endmodule

// File: rtl/utn_datapath.sv
module utn_datapath #(
   parameter int WORD_DEPTH = utn_pkg::WORD_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            req_in_char,
   input  logic                  req_line_end,
   input  utn_pkg::utn_cmd_type  cmd,
   output utn_pkg::utn_status_type status,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_out_char,
   output logic                  rsp_char_valid,
   output logic                  rsp_last_of_line
);
   import utn_pkg::*;

   localparam int FILL_W = $clog2(WORD_DEPTH + 1);
   localparam int AW     = $clog2(WORD_DEPTH);

   // word buffer
   logic [7:0]        word_store [WORD_DEPTH];
   logic [7:0]        rdata_ff;

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic              dash_ff, dash_in;
   logic              comment_ff, comment_in;
   logic              line_end_ff, line_end_in;
   logic [3:0]        pend_ff, pend_in;
   logic [7:0]        cchar_ff, cchar_in;
   logic [7:0]        cur_ff, cur_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        out_char_ff;
   logic              char_valid_ff;
   logic              last_ff;

   // decode of the incoming byte
   logic       ws_c, dash_go, del_word, slot_a, slot_b, slot_c, slot_d;
   logic       set_comment, set_dash, dash_after;
   logic [7:0] c_char;

   always_comb begin
      ws_c        = is_ws(req_in_char);
      dash_go     = !comment_ff && dash_ff;
      del_word    = dash_go && ws_c;
      slot_a      = dash_go && !ws_c;
      slot_b      = 1'b0;
      slot_c      = 1'b0;
      set_comment = 1'b0;
      set_dash    = 1'b0;
      c_char      = req_in_char;
      if (!comment_ff) begin
         unique case (req_in_char)
            CH_NUL, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK,
            CH_COLON, CH_QUEST, CH_BANG, CH_LF: begin
            end
            CH_COMMA, CH_BSLASH: begin
               slot_b = 1'b1;
            end
            CH_HASH: begin
               set_comment = 1'b1;
            end
            CH_DASH: begin
               set_dash = 1'b1;
            end
            CH_DOT, CH_APOS: begin
               slot_b = 1'b1;
               slot_c = 1'b1;
            end
            default: begin
               slot_c = 1'b1;
               if ((req_in_char >= CH_LOW_A) && (req_in_char <= CH_LOW_Z)) begin
                  c_char = req_in_char - CASE_OFS;
               end
            end
         endcase
      end
      dash_after = comment_ff ? dash_ff : set_dash;
      slot_d     = req_line_end && dash_after;
   end

   // state updates
   always_comb begin
      fill_in     = fill_ff;
      idx_in      = idx_ff;
      n_in        = n_ff;
      dash_in     = dash_ff;
      comment_in  = comment_ff;
      line_end_in = line_end_ff;
      pend_in     = pend_ff;
      cchar_in    = cchar_ff;
      cur_in      = cur_ff;
      if (cmd.accept) begin
         line_end_in = req_line_end;
         cchar_in    = c_char;
         n_in        = '0;
         pend_in     = {slot_d, slot_c, slot_b, slot_a};
         dash_in     = req_line_end ? 1'b0 : dash_after;
         if (req_line_end) begin
            comment_in = 1'b0;
         end else if (comment_ff) begin
            comment_in = (req_in_char != CH_HASH);
         end else begin
            comment_in = set_comment;
         end
         if (del_word) begin
            fill_in = FILL_W'(1);
         end
      end
      // next push in model order: dash, space, character, trailing dash
      if (cmd.take_slot) begin
         priority if (pend_ff[0]) begin
            cur_in     = CH_DASH;
            pend_in[0] = 1'b0;
         end else if (pend_ff[1]) begin
            cur_in     = CH_SPACE;
            pend_in[1] = 1'b0;
         end else if (pend_ff[2]) begin
            cur_in     = cchar_ff;
            pend_in[2] = 1'b0;
         end else begin
            cur_in     = CH_DASH;
            pend_in[3] = 1'b0;
         end
      end
      if (cmd.emit) begin
         n_in   = n_ff + CNT_W'(1);
         idx_in = idx_ff + FILL_W'(1);
      end
      if (cmd.skip) begin
         idx_in = idx_ff + FILL_W'(1);
      end
      if (cmd.flush_end) begin
         fill_in = '0;
         idx_in  = '0;
      end
      if (cmd.push_wr) begin
         fill_in = fill_ff + FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         idx_ff      <= '0;
         n_ff        <= '0;
         dash_ff     <= 1'b0;
         comment_ff  <= 1'b0;
         line_end_ff <= 1'b0;
         pend_ff     <= '0;
      end else begin
         fill_ff     <= fill_in;
         idx_ff      <= idx_in;
         n_ff        <= n_in;
         dash_ff     <= dash_in;
         comment_ff  <= comment_in;
         line_end_ff <= line_end_in;
         pend_ff     <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cchar_ff <= cchar_in;
      cur_ff   <= cur_in;
   end

   // buffer write and registered read
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [7:0]    mem_wd;

   always_comb begin
      mem_we = 1'b0;
      mem_wa = fill_ff[AW-1:0];
      mem_wd = cur_ff;
      if (cmd.accept && del_word) begin
         mem_we = 1'b1;
         mem_wa = '0;
         mem_wd = CH_SPACE;
      end else if (cmd.push_wr) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         word_store[mem_wa] <= mem_wd;
      end
      if (cmd.rd) begin
         rdata_ff <= word_store[idx_ff[AW-1:0]];
      end
   end

   // output register
   logic out_free;
   logic emit_last;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_last = line_end_ff &&
                      ((n_ff == CNT_W'(MAX_RESULTS - 1)) ||
                       (cmd.final_flush && ((idx_ff + FILL_W'(1)) == fill_ff)));

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit || cmd.marker) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_char_ff   <= rdata_ff;
         char_valid_ff <= 1'b1;
         last_ff       <= emit_last;
      end else if (cmd.marker) begin
         out_char_ff   <= CH_NUL;
         char_valid_ff <= 1'b0;
         last_ff       <= 1'b1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_char     = out_char_ff;
   assign rsp_char_valid   = char_valid_ff;
   assign rsp_last_of_line = last_ff;

   // status to controller
   always_comb begin
      status.slot_any    = |pend_ff;
      status.need_flush  = is_ws(cur_ff) || (fill_ff == FILL_W'(WORD_DEPTH));
      status.idx_at_fill = (idx_ff == fill_ff);
      status.capped      = (n_ff >= CNT_W'(MAX_RESULTS));
      status.out_free    = out_free;
      status.line_end    = line_end_ff;
      status.n_zero      = (n_ff == '0);
   end

   // a write into the buffer always finds a free entry
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.push_wr |-> (fill_ff < FILL_W'(WORD_DEPTH)))
      else $error("push into full word buffer");

   // no result goes out beyond the per-transaction limit
   a_emit_cap: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (n_ff < CNT_W'(MAX_RESULTS)) && out_free)
      else $error("emit past result limit or into busy output");

   // an end marker only closes an utterance
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !char_valid_ff) |-> last_ff)
      else $error("end marker without last_of_line");

   // flush reads stay below the fill level
   a_read_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |-> (idx_ff < fill_ff))
      else $error("buffer read beyond fill");

endmodule

// File: rtl/utn_controller.sv
module utn_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  utn_pkg::utn_status_type status,
   output utn_pkg::utn_cmd_type    cmd
);
   import utn_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DISP  = 3'd1;
   localparam logic [2:0] S_PCHK  = 3'd2;
   localparam logic [2:0] S_FRD   = 3'd3;
   localparam logic [2:0] S_FEMIT = 3'd4;
   localparam logic [2:0] S_PWR   = 3'd5;
   localparam logic [2:0] S_END   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       final_ff, final_in;

   // sequencing of pushes and flushes
   always_comb begin
      state_in        = state_ff;
      final_in        = final_ff;
      cmd             = '0;
      cmd.final_flush = final_ff;
      req_stall       = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DISP;
            end
         end
         S_DISP: begin
            if (status.slot_any) begin
               cmd.take_slot = 1'b1;
               state_in      = S_PCHK;
            end else if (status.line_end) begin
               final_in = 1'b1;
               state_in = S_FRD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PCHK: begin
            if (status.need_flush) begin
               final_in = 1'b0;
               state_in = S_FRD;
            end else begin
               cmd.push_wr = 1'b1;
               state_in    = S_DISP;
            end
         end
         S_FRD: begin
            if (status.idx_at_fill) begin
               cmd.flush_end = 1'b1;
               state_in      = final_ff ? S_END : S_PWR;
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_FEMIT;
            end
         end
         S_FEMIT: begin
            if (status.capped) begin
               cmd.skip = 1'b1;
               state_in = S_FRD;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_FRD;
            end
         end
         S_PWR: begin
            cmd.push_wr = 1'b1;
            state_in    = S_DISP;
         end
         S_END: begin
            if (!status.n_zero) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.marker = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         final_ff <= final_in;
      end
   end

   // input is taken only when idle
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff == S_DISP))
      else $error("accept did not start dispatch");

   // the end state is reached only from a final flush
   a_end_final: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_END) |-> final_ff)
      else $error("end state without final flush");

   // a push write after a flush follows an empty buffer
   a_pwr_after_flush: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PWR) |-> $past(cmd.flush_end))
      else $error("push write without preceding flush");

endmodule
